// File: hw/rtl/contiguous_frame_allocator_assert.svh
// Assertion macros used by the allocator checker
`ifndef CONTIGUOUS_FRAME_ALLOCATOR_ASSERT_SVH
`define CONTIGUOUS_FRAME_ALLOCATOR_ASSERT_SVH

// Implication checked in the same cycle
`define CFA_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Implication checked in the next cycle
`define CFA_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: hw/rtl/cfa_pkg.sv
// Package of the contiguous frame allocator: codes, widths and defaults
`default_nettype none
package cfa_pkg;
   localparam int MAX_FRAMES_DEF = 4096;
   localparam int FRAME_W = 20;
   localparam int COUNT_W = 13;
   localparam int STATUS_W = 3;
   localparam int EXT_W = 22;

   localparam logic [1:0] ST_FREE     = 2'h0;
   localparam logic [1:0] ST_HEAD     = 2'h1;
   localparam logic [1:0] ST_UNUSABLE = 2'h2;
   localparam logic [1:0] ST_USED     = 2'h3;

   localparam logic [2:0] RS_OK        = 3'd0;
   localparam logic [2:0] RS_NO_RUN    = 3'd1;
   localparam logic [2:0] RS_NOT_HEAD  = 3'd2;
   localparam logic [2:0] RS_RANGE     = 3'd3;
   localparam logic [2:0] RS_BAD_COUNT = 3'd4;

   localparam logic [1:0] OP_INIT    = 2'd0;
   localparam logic [1:0] OP_ALLOC   = 2'd1;
   localparam logic [1:0] OP_MARK    = 2'd2;
   localparam logic [1:0] OP_RELEASE = 2'd3;

   localparam logic [1:0] CSR_BASE    = 2'd0;
   localparam logic [1:0] CSR_POOL    = 2'd1;
   localparam logic [1:0] CSR_RESERVE = 2'd2;
endpackage
`default_nettype wire

// File: hw/rtl/cfa_ram.sv
// Generic simple dual-port RAM with registered read
`default_nettype none
module cfa_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule
`default_nettype wire

// File: hw/rtl/contiguous_frame_allocator.sv
// Bad count, oversize and range errors answer straight from idle; init sweeps the whole map;
// allocate runs a first-fit scan over the pool, one map entry a cycle, then writes the run,
// one write a cycle; mark writes its run; release reads, checks and frees each run entry in turn.
// One transaction at a time; busy is high while a multi-cycle transaction runs and drops
// in the cycle its response strobe shows, when the next transaction may be accepted.
// Synchronous reset runs a clearing pass over the whole map with busy high.
`default_nettype none
module contiguous_frame_allocator #(
   parameter int MAX_FRAMES = cfa_pkg::MAX_FRAMES_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [1:0]                    req_op,
   input  wire logic [cfa_pkg::FRAME_W-1:0]   req_frame,
   input  wire logic [cfa_pkg::COUNT_W-1:0]   req_count,
   output logic                               rsp_valid,
   output logic      [cfa_pkg::FRAME_W-1:0]   rsp_first_frame,
   output logic      [cfa_pkg::STATUS_W-1:0]  rsp_status,
   output logic      [cfa_pkg::COUNT_W-1:0]   rsp_free_left,
   input  wire logic                          csr_we,
   input  wire logic [1:0]                    csr_index,
   input  wire logic [cfa_pkg::FRAME_W-1:0]   csr_wdata
);
   localparam int AW = $clog2(MAX_FRAMES);
   localparam int FW = $clog2(MAX_FRAMES + 1);
   localparam int NW0 = (FW > AW + 1) ? FW : AW + 1;
   localparam int NW = (NW0 > cfa_pkg::COUNT_W) ? NW0 : cfa_pkg::COUNT_W;
   localparam int EW = cfa_pkg::EXT_W;

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_CLEAR   = 3'd1;
   localparam logic [2:0] S_SCAN    = 3'd2;
   localparam logic [2:0] S_FILL    = 3'd3;
   localparam logic [2:0] S_REL_RD  = 3'd4;
   localparam logic [2:0] S_REL_CHK = 3'd5;

   // configuration registers
   logic [cfa_pkg::FRAME_W-1:0] base_ff;
   logic [cfa_pkg::COUNT_W-1:0] pool_ff;
   logic                        reserve_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff    <= '0;
         pool_ff    <= cfa_pkg::COUNT_W'(4096);
         reserve_ff <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_index)
            cfa_pkg::CSR_BASE:    base_ff <= csr_wdata;
            cfa_pkg::CSR_POOL:    pool_ff <= csr_wdata[cfa_pkg::COUNT_W-1:0];
            cfa_pkg::CSR_RESERVE: reserve_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // control and datapath registers
   logic [2:0]                  state_ff, state_in;
   logic [NW-1:0]               ptr_ff, ptr_in;
   logic [NW-1:0]               start_ff, start_in;
   logic [NW-1:0]               end_ff, end_in;
   logic [NW-1:0]               run_ff, run_in;
   logic [NW-1:0]               chk_addr_ff, chk_addr_in;
   logic                        chk_vld_ff, chk_vld_in;
   logic [NW-1:0]               cnt_ff, cnt_in;
   logic [1:0]                  op_ff, op_in;
   logic                        head_ff, head_in;
   logic                        pend_ff, pend_in;
   logic [FW-1:0]               free_ff, free_in;
   logic [cfa_pkg::FRAME_W-1:0] first_ff, first_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [cfa_pkg::FRAME_W-1:0] rsp_first_ff, rsp_first_in;
   logic [2:0]                  rsp_status_ff, rsp_status_in;
   logic [cfa_pkg::COUNT_W-1:0] rsp_free_ff, rsp_free_in;

   // map memory ports
   logic          wr_en, rd_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [1:0]    wr_data, rd_data;

   cfa_ram #(
      .WIDTH(2),
      .DEPTH(MAX_FRAMES)
   ) u_map (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // effective pool size and range terms
   logic [NW-1:0] pool_n, max_n, count_n;
   logic [EW-1:0] lo_e, hi_e, frame_e, end_e;
   logic [FW-1:0] free_dec, free_inc;
   logic [EW-1:0] free_ext;
   logic          fin;
   logic [2:0]    fin_status;
   logic [cfa_pkg::FRAME_W-1:0] fin_first;

   assign max_n   = NW'(MAX_FRAMES);
   assign pool_n  = (NW'(pool_ff) > max_n) ? max_n : NW'(pool_ff);
   assign count_n = NW'(req_count);
   assign lo_e    = EW'(base_ff);
   assign hi_e    = EW'(base_ff) + EW'(pool_n);
   assign frame_e = EW'(req_frame);
   assign end_e   = EW'(req_frame) + EW'(req_count);
   assign free_dec = (free_ff == '0) ? '0 : free_ff - FW'(1);
   assign free_inc = (free_ff == FW'(MAX_FRAMES)) ? free_ff : free_ff + FW'(1);

   always_comb begin
      state_in    = state_ff;
      ptr_in      = ptr_ff;
      start_in    = start_ff;
      end_in      = end_ff;
      run_in      = run_ff;
      chk_addr_in = chk_addr_ff;
      chk_vld_in  = 1'b0;
      cnt_in      = cnt_ff;
      op_in       = op_ff;
      head_in     = head_ff;
      pend_in     = pend_ff;
      free_in     = free_ff;
      first_in    = first_ff;
      fin         = 1'b0;
      fin_status  = cfa_pkg::RS_OK;
      fin_first   = '0;
      wr_en       = 1'b0;
      wr_addr     = ptr_ff[AW-1:0];
      wr_data     = cfa_pkg::ST_FREE;
      rd_en       = 1'b0;
      rd_addr     = ptr_ff[AW-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in  = req_op;
               cnt_in = count_n;
               unique case (req_op)
                  cfa_pkg::OP_INIT: begin
                     head_in  = reserve_ff && (pool_n != '0);
                     free_in  = FW'(pool_n) - FW'(reserve_ff && (pool_n != '0));
                     pend_in  = 1'b1;
                     ptr_in   = '0;
                     state_in = S_CLEAR;
                  end
                  cfa_pkg::OP_ALLOC: begin
                     if (req_count == '0) begin
                        fin = 1'b1;
                        fin_status = cfa_pkg::RS_BAD_COUNT;
                     end else if (count_n > pool_n || count_n > NW'(free_ff)) begin
                        fin = 1'b1;
                        fin_status = cfa_pkg::RS_NO_RUN;
                     end else begin
                        ptr_in   = '0;
                        run_in   = '0;
                        state_in = S_SCAN;
                     end
                  end
                  cfa_pkg::OP_MARK: begin
                     if (req_count == '0) begin
                        fin = 1'b1;
                        fin_status = cfa_pkg::RS_BAD_COUNT;
                     end else if (frame_e < lo_e || end_e > hi_e) begin
                        fin = 1'b1;
                        fin_status = cfa_pkg::RS_RANGE;
                     end else begin
                        ptr_in   = NW'(frame_e - lo_e);
                        end_in   = NW'(end_e - lo_e);
                        first_in = '0;
                        state_in = S_FILL;
                     end
                  end
                  default: begin
                     if (frame_e < lo_e || frame_e >= hi_e) begin
                        fin = 1'b1;
                        fin_status = cfa_pkg::RS_RANGE;
                     end else begin
                        ptr_in   = NW'(frame_e - lo_e);
                        start_in = NW'(frame_e - lo_e);
                        state_in = S_REL_RD;
                     end
                  end
               endcase
            end
         end

         // sweep the whole map, head at frame 0 when asked
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_data = (ptr_ff == '0 && head_ff) ? cfa_pkg::ST_HEAD : cfa_pkg::ST_FREE;
            ptr_in  = ptr_ff + NW'(1);
            if (ptr_ff == max_n - NW'(1)) begin
               state_in = S_IDLE;
               pend_in  = 1'b0;
               fin      = pend_ff;
            end
         end

         // first-fit scan: issue one read a cycle, check the one before
         S_SCAN: begin
            if (ptr_ff < pool_n) begin
               rd_en       = 1'b1;
               chk_vld_in  = 1'b1;
               chk_addr_in = ptr_ff;
               ptr_in      = ptr_ff + NW'(1);
            end
            if (chk_vld_ff) begin
               if (rd_data == cfa_pkg::ST_FREE) begin
                  run_in = run_ff + NW'(1);
               end else begin
                  run_in = '0;
               end
               if (rd_data == cfa_pkg::ST_FREE && run_ff + NW'(1) == cnt_ff) begin
                  start_in   = chk_addr_ff + NW'(1) - cnt_ff;
                  ptr_in     = chk_addr_ff + NW'(1) - cnt_ff;
                  end_in     = chk_addr_ff + NW'(1);
                  first_in   = cfa_pkg::FRAME_W'(EW'(base_ff)
                                 + EW'(chk_addr_ff + NW'(1) - cnt_ff));
                  chk_vld_in = 1'b0;
                  state_in   = S_FILL;
               end else if (chk_addr_ff == pool_n - NW'(1)) begin
                  chk_vld_in = 1'b0;
                  fin        = 1'b1;
                  fin_status = cfa_pkg::RS_NO_RUN;
                  state_in   = S_IDLE;
               end
            end
         end

         // write the run: head and used frames, or unusable frames
         S_FILL: begin
            wr_en = 1'b1;
            if (op_ff == cfa_pkg::OP_MARK) begin
               wr_data = cfa_pkg::ST_UNUSABLE;
            end else if (ptr_ff == start_ff) begin
               wr_data = cfa_pkg::ST_HEAD;
            end else begin
               wr_data = cfa_pkg::ST_USED;
            end
            free_in = free_dec;
            ptr_in  = ptr_ff + NW'(1);
            if (ptr_ff + NW'(1) == end_ff) begin
               fin       = 1'b1;
               fin_first = first_ff;
               state_in  = S_IDLE;
            end
         end

         S_REL_RD: begin
            rd_en    = 1'b1;
            state_in = S_REL_CHK;
         end

         // free the head, then the used frames behind it
         S_REL_CHK: begin
            if (ptr_ff == start_ff && rd_data != cfa_pkg::ST_HEAD) begin
               fin        = 1'b1;
               fin_status = cfa_pkg::RS_NOT_HEAD;
               state_in   = S_IDLE;
            end else if (ptr_ff != start_ff && rd_data != cfa_pkg::ST_USED) begin
               fin      = 1'b1;
               state_in = S_IDLE;
            end else begin
               wr_en   = 1'b1;
               wr_data = cfa_pkg::ST_FREE;
               free_in = free_inc;
               ptr_in  = ptr_ff + NW'(1);
               if (ptr_ff + NW'(1) >= pool_n) begin
                  fin      = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  state_in = S_REL_RD;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // response fields
   assign free_ext      = EW'(free_in);
   assign rsp_valid_in  = fin;
   assign rsp_first_in  = fin_first;
   assign rsp_status_in = fin_status;
   assign rsp_free_in   = free_ext[cfa_pkg::COUNT_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         ptr_ff       <= '0;
         chk_vld_ff   <= 1'b0;
         head_ff      <= 1'b0;
         pend_ff      <= 1'b0;
         free_ff      <= FW'(MAX_FRAMES);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         chk_vld_ff   <= chk_vld_in;
         head_ff      <= head_in;
         pend_ff      <= pend_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      start_ff      <= start_in;
      end_ff        <= end_in;
      run_ff        <= run_in;
      chk_addr_ff   <= chk_addr_in;
      cnt_ff        <= cnt_in;
      op_ff         <= op_in;
      first_ff      <= first_in;
      rsp_first_ff  <= rsp_first_in;
      rsp_status_ff <= rsp_status_in;
      rsp_free_ff   <= rsp_free_in;
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_first_frame = rsp_first_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_free_left   = rsp_free_ff;
endmodule
`default_nettype wire

// File: hw/rtl/cfa_checker.sv
// Port checker of the contiguous frame allocator and its bind
`default_nettype none
`include "contiguous_frame_allocator_assert.svh"
module cfa_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         start,
   input wire logic                         busy,
   input wire logic                         rsp_valid,
   input wire logic [cfa_pkg::FRAME_W-1:0]  rsp_first_frame,
   input wire logic [cfa_pkg::STATUS_W-1:0] rsp_status
);
   // a response ends the transaction and frees the block
   `CFA_ASSERT_IMP(a_rsp_idle, clock, reset, rsp_valid, !busy)
   // status codes stay in their range
   `CFA_ASSERT_IMP(a_status_rng, clock, reset, rsp_valid, rsp_status <= cfa_pkg::RS_BAD_COUNT)
   // failures carry no frame
   `CFA_ASSERT_IMP(a_fail_zero, clock, reset, rsp_valid && rsp_status != cfa_pkg::RS_OK, rsp_first_frame == '0)
   // an accepted transaction either keeps the block busy or gets its response
   `CFA_ASSERT_NXT(a_busy_hold, clock, reset, start && !busy, busy || rsp_valid)
endmodule

bind contiguous_frame_allocator cfa_checker u_cfa_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_valid      (rsp_valid),
   .rsp_first_frame(rsp_first_frame),
   .rsp_status     (rsp_status)
);
`default_nettype wire

// File: dv/tb.sv
// Self-checking testbench for the contiguous frame allocator
`default_nettype none
module tb;
   localparam int MAXF       = cfa_pkg::MAX_FRAMES_DEF;
   localparam int IDLE_LIMIT = 60000;

   typedef struct {
      bit              is_csr;
      logic [1:0]      op;
      logic [19:0]     frame;
      logic [12:0]     count;
      logic [1:0]      idx;
      logic [19:0]     data;
   } txn_type;

   typedef struct {
      logic [19:0] first_frame;
      logic [2:0]  status;
      logic [12:0] free_left;
   } alloc_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_op = cfa_pkg::OP_INIT;
   logic [19:0] req_frame = '0;
   logic [12:0] req_count = '0;
   logic        rsp_valid;
   logic [19:0] rsp_first_frame;
   logic [2:0]  rsp_status;
   logic [12:0] rsp_free_left;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = cfa_pkg::CSR_BASE;
   logic [19:0] csr_wdata = '0;

   contiguous_frame_allocator dut (.*);

   always #5 clock = ~clock;

   // shadow state of the allocator
   logic [1:0]  shadow_map [MAXF];
   int          shadow_free = MAXF;
   logic [19:0] shadow_base = '0;
   logic [12:0] shadow_pool = 13'd4096;
   bit          shadow_reserve = 1'b1;

   txn_type        pending_q[$];
   alloc_rsp_type  expected_q[$];

   // stimulus-side view of the configuration
   int          gen_base = 0;
   int          gen_pool = 4096;

   int          mismatches = 0;
   int          op_seen[4] = '{0, 0, 0, 0};
   int          csr_writes = 0;
   int          rsp_seen = 0;
   int          burst_left = 0;
   int          gap_left = 0;
   int          idle_cycles = 0;

   initial foreach (shadow_map[i]) shadow_map[i] = cfa_pkg::ST_FREE;

   // predict one transaction and update the shadow state
   function automatic alloc_rsp_type predict_alloc(input logic [1:0] op,
                                                   input logic [19:0] frame,
                                                   input logic [12:0] count);
      alloc_rsp_type r;
      int n, run, first_i, i;
      bit found;
      longint lo, hi, stop_v;
      n = (shadow_pool > MAXF) ? MAXF : shadow_pool;
      r.first_frame = '0;
      r.status = cfa_pkg::RS_OK;
      found = 1'b0;
      first_i = 0;
      run = 0;
      case (op)
         cfa_pkg::OP_INIT: begin
            foreach (shadow_map[k]) shadow_map[k] = cfa_pkg::ST_FREE;
            shadow_free = n;
            if (shadow_reserve && n > 0) begin
               shadow_map[0] = cfa_pkg::ST_HEAD;
               if (shadow_free > 0) shadow_free--;
            end
         end
         cfa_pkg::OP_ALLOC: begin
            if (count == 0) r.status = cfa_pkg::RS_BAD_COUNT;
            else if (count > n || count > shadow_free) r.status = cfa_pkg::RS_NO_RUN;
            else begin
               for (i = 0; i < n && !found; i++) begin
                  if (shadow_map[i] == cfa_pkg::ST_FREE) begin
                     run++;
                     if (run == count) begin
                        first_i = i + 1 - count;
                        found = 1'b1;
                     end
                  end else run = 0;
               end
               if (!found) r.status = cfa_pkg::RS_NO_RUN;
               else begin
                  shadow_map[first_i] = cfa_pkg::ST_HEAD;
                  for (i = first_i + 1; i < first_i + count; i++)
                     shadow_map[i] = cfa_pkg::ST_USED;
                  shadow_free = (shadow_free > count) ? shadow_free - count : 0;
                  r.first_frame = 20'(shadow_base + first_i);
               end
            end
         end
         cfa_pkg::OP_MARK: begin
            lo = shadow_base;
            hi = longint'(shadow_base) + n;
            stop_v = longint'(frame) + count;
            if (count == 0) r.status = cfa_pkg::RS_BAD_COUNT;
            else if (frame < lo || stop_v > hi) r.status = cfa_pkg::RS_RANGE;
            else begin
               for (i = frame - shadow_base; i < frame - shadow_base + count; i++) begin
                  shadow_map[i] = cfa_pkg::ST_UNUSABLE;
                  if (shadow_free > 0) shadow_free--;
               end
            end
         end
         default: begin
            if (frame < shadow_base || longint'(frame) >= longint'(shadow_base) + n)
               r.status = cfa_pkg::RS_RANGE;
            else if (shadow_map[frame - shadow_base] != cfa_pkg::ST_HEAD)
               r.status = cfa_pkg::RS_NOT_HEAD;
            else begin
               i = frame - shadow_base;
               shadow_map[i] = cfa_pkg::ST_FREE;
               if (shadow_free < MAXF) shadow_free++;
               for (i = i + 1; i < n && shadow_map[i] == cfa_pkg::ST_USED; i++) begin
                  shadow_map[i] = cfa_pkg::ST_FREE;
                  if (shadow_free < MAXF) shadow_free++;
               end
            end
         end
      endcase
      r.free_left = 13'(shadow_free);
      return r;
   endfunction

   // driver: offer transactions in bursts, write registers only when idle
   always @(posedge clock) begin
      logic take, nxt_start, nxt_we;
      txn_type t;
      if (reset) begin
         start <= 1'b0;
         csr_we <= 1'b0;
      end else begin
         take = start && !busy;
         nxt_start = start && !take;
         nxt_we = 1'b0;
         if (take) begin
            expected_q.push_back(predict_alloc(req_op, req_frame, req_count));
            op_seen[req_op]++;
         end
         if (!nxt_start && pending_q.size() > 0) begin
            if (gap_left > 0) gap_left--;
            else begin
               t = pending_q[0];
               if (t.is_csr) begin
                  if (!take && !start && !busy && expected_q.size() == 0) begin
                     case (t.idx)
                        cfa_pkg::CSR_BASE: shadow_base = t.data;
                        cfa_pkg::CSR_POOL: shadow_pool = t.data[12:0];
                        default:           shadow_reserve = t.data[0];
                     endcase
                     csr_index <= t.idx;
                     csr_wdata <= t.data;
                     nxt_we = 1'b1;
                     csr_writes++;
                     void'(pending_q.pop_front());
                  end
               end else begin
                  req_op <= t.op;
                  req_frame <= t.frame;
                  req_count <= t.count;
                  nxt_start = 1'b1;
                  void'(pending_q.pop_front());
                  if (burst_left > 0) burst_left--;
                  else begin
                     burst_left = $urandom_range(0, 7);
                     gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                  end
               end
            end
         end
         start <= nxt_start;
         csr_we <= nxt_we;
      end
   end

   // monitor: compare each response with the oldest prediction
   always @(posedge clock) begin
      alloc_rsp_type e;
      if (!reset && rsp_valid) begin
         rsp_seen++;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response: first=%h status=%0d free=%0d",
                                           rsp_first_frame, rsp_status, rsp_free_left);
         end else begin
            e = expected_q.pop_front();
            if (rsp_first_frame !== e.first_frame || rsp_status !== e.status ||
                rsp_free_left !== e.free_left) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch #%0d: first %h/%h status %0d/%0d free %0d/%0d (exp/act)",
                           rsp_seen, e.first_frame, rsp_first_frame, e.status, rsp_status,
                           e.free_left, rsp_free_left);
            end
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_we) idle_cycles <= 0;
      else if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout after %0d idle cycles", idle_cycles);
         $display("FAIL");
         $finish;
      end else idle_cycles <= idle_cycles + 1;
   end

   task automatic add_op(input logic [1:0] op, input int frame, input int count);
      txn_type t;
      t.is_csr = 1'b0;
      t.op = op;
      t.frame = 20'(frame);
      t.count = 13'(count);
      t.idx = cfa_pkg::CSR_BASE;
      t.data = '0;
      pending_q.push_back(t);
   endtask

   task automatic add_csr(input logic [1:0] idx, input int data);
      txn_type t;
      t.is_csr = 1'b1;
      t.op = cfa_pkg::OP_INIT;
      t.frame = '0;
      t.count = '0;
      t.idx = idx;
      t.data = 20'(data);
      pending_q.push_back(t);
      if (idx == cfa_pkg::CSR_BASE) gen_base = data;
      else if (idx == cfa_pkg::CSR_POOL) gen_pool = (data > MAXF) ? MAXF : data;
   endtask

   // mostly well-formed traffic inside the pool, some wild values
   task automatic add_random(input int num);
      int r, lim;
      for (int k = 0; k < num; k++) begin
         r = $urandom_range(0, 99);
         lim = (gen_pool / 3 > 1) ? gen_pool / 3 : 1;
         if (r < 45)
            add_op(cfa_pkg::OP_ALLOC, $urandom,
                   ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191)
                                               : $urandom_range(1, lim));
         else if (r < 80)
            add_op(cfa_pkg::OP_RELEASE, ($urandom_range(0, 9) == 0 || gen_pool == 0) ? $urandom
                   : gen_base + $urandom_range(0, gen_pool - 1), $urandom);
         else if (r < 94)
            add_op(cfa_pkg::OP_MARK, ($urandom_range(0, 5) == 0 || gen_pool == 0) ? $urandom
                   : gen_base + $urandom_range(0, gen_pool - 1),
                   ($urandom_range(0, 5) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 3));
         else add_op(cfa_pkg::OP_INIT, $urandom, $urandom);
      end
   endtask

   initial begin
      // directed: defaults after reset, whole map free
      add_op(cfa_pkg::OP_ALLOC, 0, 0);
      add_op(cfa_pkg::OP_ALLOC, 0, 8191);
      add_op(cfa_pkg::OP_ALLOC, 0, 4096);
      add_op(cfa_pkg::OP_ALLOC, 0, 1);
      add_op(cfa_pkg::OP_RELEASE, 0, 0);
      add_op(cfa_pkg::OP_RELEASE, 1, 0);
      add_op(cfa_pkg::OP_RELEASE, 4096, 0);
      add_op(cfa_pkg::OP_RELEASE, 20'hFFFFF, 8191);
      add_op(cfa_pkg::OP_ALLOC, 0, 3);
      add_op(cfa_pkg::OP_ALLOC, 0, 5);
      add_op(cfa_pkg::OP_MARK, 1, 1);
      add_op(cfa_pkg::OP_RELEASE, 0, 0);
      add_op(cfa_pkg::OP_MARK, 0, 0);
      add_op(cfa_pkg::OP_MARK, 4094, 3);
      add_op(cfa_pkg::OP_MARK, 4095, 1);
      add_op(cfa_pkg::OP_MARK, 20'hFFFFF, 8191);
      add_op(cfa_pkg::OP_RELEASE, 3, 0);
      add_op(cfa_pkg::OP_INIT, 0, 0);
      add_op(cfa_pkg::OP_ALLOC, 0, 2);
      add_op(cfa_pkg::OP_RELEASE, 0, 0);

      // small pool whose addresses wrap past the top
      add_csr(cfa_pkg::CSR_BASE, 20'hFFFF8);
      add_csr(cfa_pkg::CSR_POOL, 24);
      add_csr(cfa_pkg::CSR_RESERVE, 0);
      add_op(cfa_pkg::OP_INIT, 0, 0);
      add_random(35);

      add_csr(cfa_pkg::CSR_BASE, 20'h12345);
      add_csr(cfa_pkg::CSR_POOL, 40);
      add_csr(cfa_pkg::CSR_RESERVE, 1);
      add_op(cfa_pkg::OP_INIT, 0, 0);
      add_random(35);

      // empty pool
      add_csr(cfa_pkg::CSR_POOL, 0);
      add_op(cfa_pkg::OP_INIT, 0, 0);
      add_op(cfa_pkg::OP_ALLOC, 0, 1);
      add_op(cfa_pkg::OP_MARK, 20'h12345, 1);
      add_op(cfa_pkg::OP_RELEASE, 20'h12345, 0);

      // oversize register clipped to the full map
      add_csr(cfa_pkg::CSR_BASE, 0);
      add_csr(cfa_pkg::CSR_POOL, 8191);
      add_op(cfa_pkg::OP_INIT, 0, 0);
      add_op(cfa_pkg::OP_ALLOC, 0, 4095);
      add_op(cfa_pkg::OP_RELEASE, 1, 0);
      add_random(6);

      add_csr(cfa_pkg::CSR_POOL, 1);
      add_op(cfa_pkg::OP_INIT, 0, 0);
      add_op(cfa_pkg::OP_ALLOC, 0, 1);
      add_op(cfa_pkg::OP_RELEASE, 0, 0);
      add_op(cfa_pkg::OP_ALLOC, 0, 1);
      add_random(6);

      add_csr(cfa_pkg::CSR_BASE, 20'hFFFFF);
      add_csr(cfa_pkg::CSR_POOL, 16);
      add_csr(cfa_pkg::CSR_RESERVE, 0);
      add_op(cfa_pkg::OP_INIT, 0, 0);
      add_random(25);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      wait (pending_q.size() == 0 && expected_q.size() == 0 && !start);
      repeat (50) @(posedge clock);

      $display("covered %0d init, %0d allocate, %0d mark, %0d release transactions",
               op_seen[cfa_pkg::OP_INIT], op_seen[cfa_pkg::OP_ALLOC],
               op_seen[cfa_pkg::OP_MARK], op_seen[cfa_pkg::OP_RELEASE]);
      $display("%0d register writes, %0d responses checked, %0d mismatches",
               csr_writes, rsp_seen, mismatches);
      if (mismatches == 0 && expected_q.size() == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end
endmodule
`default_nettype wire
